// ===== design/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // error codes
    localparam logic [2:0] ERR_NONE           = 3'd0;
    localparam logic [2:0] ERR_UNTERM_STRING  = 3'd1;
    localparam logic [2:0] ERR_UNTERM_ESCAPE  = 3'd2;
    localparam logic [2:0] ERR_BAD_ESCAPE     = 3'd3;
    localparam logic [2:0] ERR_INCOMPLETE_UNI = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX        = 3'd5;

    // decoder modes; codes 6 and 7 behave as body
    typedef enum logic [2:0] {
        MODE_BODY = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_HEX2 = 3'd3,
        MODE_HEX3 = 3'd4,
        MODE_HEX4 = 3'd5
    } t_mode;

    // one result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [2:0] err;
    } t_result;

    localparam int MAX_RESULTS = 4;

    // all results caused by one input byte
    typedef struct packed {
        logic [2:0]                        count;
        t_result [MAX_RESULTS-1:0]         res;
    } t_group;

endpackage
`default_nettype wire

// ===== design/jsu_decode.sv =====
`default_nettype none
module jsu_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_text_ends,
    input  wire logic           i_commit,
    output jsu_pkg::t_group     o_group
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    jsu_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_accum, n_accum;
    logic           r_hex_bad, n_hex_bad;

    logic [3:0]  hex_val;
    logic        hex_ok;
    logic [7:0]  esc_byte;
    logic        esc_ok;
    logic [15:0] accum_shift;
    logic        bad_next;

    // hex digit decode, either case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_data_byte >= 8'h30 && i_data_byte <= 8'h39) begin
            hex_val = 4'(i_data_byte - 8'h30);
        end else if (i_data_byte >= 8'h61 && i_data_byte <= 8'h66) begin
            hex_val = 4'(i_data_byte - 8'h57);
        end else if (i_data_byte >= 8'h41 && i_data_byte <= 8'h46) begin
            hex_val = 4'(i_data_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // single character escapes
    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = 8'h00;
        case (i_data_byte)
            8'h22: esc_byte = 8'h22;
            8'h5C: esc_byte = 8'h5C;
            8'h2F: esc_byte = 8'h2F;
            8'h62: esc_byte = 8'h08;
            8'h66: esc_byte = 8'h0C;
            8'h6E: esc_byte = 8'h0A;
            8'h72: esc_byte = 8'h0D;
            8'h74: esc_byte = 8'h09;
            default: esc_ok = 1'b0;
        endcase
    end

    assign accum_shift = {r_accum[11:0], hex_val};
    assign bad_next    = r_hex_bad | ~hex_ok;

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_accum   = r_accum;
        n_hex_bad = r_hex_bad;
        case (r_mode)
            jsu_pkg::MODE_ESC: begin
                if (i_data_byte == CH_U && !i_text_ends) begin
                    n_mode    = jsu_pkg::MODE_HEX1;
                    n_accum   = 16'd0;
                    n_hex_bad = 1'b0;
                end else begin
                    n_mode = jsu_pkg::MODE_BODY;
                    if (i_data_byte == CH_U || !esc_ok || i_text_ends) begin
                        n_accum   = 16'd0;
                        n_hex_bad = 1'b0;
                    end
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
                if (i_text_ends) begin
                    n_mode    = jsu_pkg::MODE_BODY;
                    n_accum   = 16'd0;
                    n_hex_bad = 1'b0;
                end else begin
                    n_mode    = jsu_pkg::t_mode'(r_mode + 3'd1);
                    n_accum   = accum_shift;
                    n_hex_bad = bad_next;
                end
            end
            jsu_pkg::MODE_HEX4: begin
                n_mode    = jsu_pkg::MODE_BODY;
                n_accum   = 16'd0;
                n_hex_bad = 1'b0;
            end
            default: begin
                if (i_data_byte == CH_QUOTE) begin
                    n_mode    = jsu_pkg::MODE_BODY;
                    n_accum   = 16'd0;
                    n_hex_bad = 1'b0;
                end else if (i_data_byte == CH_BSL && !i_text_ends) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end else begin
                    n_mode = jsu_pkg::MODE_BODY;
                    if (i_text_ends) begin
                        n_accum   = 16'd0;
                        n_hex_bad = 1'b0;
                    end
                end
            end
        endcase
    end

    // result group for this byte
    always_comb begin
        logic [2:0] n;
        n       = 3'd0;
        o_group = '0;
        case (r_mode)
            jsu_pkg::MODE_ESC: begin
                if (i_data_byte == CH_U) begin
                    if (i_text_ends) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                                jsu_pkg::ERR_INCOMPLETE_UNI};
                        n = n + 3'd1;
                    end
                end else if (!esc_ok) begin
                    o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                            jsu_pkg::ERR_BAD_ESCAPE};
                    n = n + 3'd1;
                end else begin
                    o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE, esc_byte, jsu_pkg::ERR_NONE};
                    n = n + 3'd1;
                    if (i_text_ends) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                                jsu_pkg::ERR_UNTERM_STRING};
                        n = n + 3'd1;
                    end
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
                if (i_text_ends) begin
                    o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                            jsu_pkg::ERR_INCOMPLETE_UNI};
                    n = n + 3'd1;
                end
            end
            jsu_pkg::MODE_HEX4: begin
                if (bad_next) begin
                    o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                            jsu_pkg::ERR_BAD_HEX};
                    n = n + 3'd1;
                end else begin
                    // utf-8 encode of the gathered code point
                    if (accum_shift <= 16'h007F) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE, accum_shift[7:0],
                                                jsu_pkg::ERR_NONE};
                        n = n + 3'd1;
                    end else if (accum_shift <= 16'h07FF) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE,
                                                8'hC0 | {3'b000, accum_shift[10:6]},
                                                jsu_pkg::ERR_NONE};
                        n = n + 3'd1;
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE,
                                                8'h80 | {2'b00, accum_shift[5:0]},
                                                jsu_pkg::ERR_NONE};
                        n = n + 3'd1;
                    end else begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE,
                                                8'hE0 | {4'h0, accum_shift[15:12]},
                                                jsu_pkg::ERR_NONE};
                        n = n + 3'd1;
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE,
                                                8'h80 | {2'b00, accum_shift[11:6]},
                                                jsu_pkg::ERR_NONE};
                        n = n + 3'd1;
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE,
                                                8'h80 | {2'b00, accum_shift[5:0]},
                                                jsu_pkg::ERR_NONE};
                        n = n + 3'd1;
                    end
                    if (i_text_ends) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                                jsu_pkg::ERR_UNTERM_STRING};
                        n = n + 3'd1;
                    end
                end
            end
            default: begin
                if (i_data_byte == CH_QUOTE) begin
                    o_group.res[n[1:0]] = '{jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_NONE};
                    n = n + 3'd1;
                end else if (i_data_byte == CH_BSL) begin
                    if (i_text_ends) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                                jsu_pkg::ERR_UNTERM_ESCAPE};
                        n = n + 3'd1;
                    end
                end else begin
                    o_group.res[n[1:0]] = '{jsu_pkg::KIND_BYTE, i_data_byte,
                                            jsu_pkg::ERR_NONE};
                    n = n + 3'd1;
                    if (i_text_ends) begin
                        o_group.res[n[1:0]] = '{jsu_pkg::KIND_ERROR, 8'h00,
                                                jsu_pkg::ERR_UNTERM_STRING};
                        n = n + 3'd1;
                    end
                end
            end
        endcase
        o_group.count = n;
    end

    // decoder state, updated when the byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_BODY;
            r_accum   <= 16'd0;
            r_hex_bad <= 1'b0;
        end else if (i_commit) begin
            r_mode    <= n_mode;
            r_accum   <= n_accum;
            r_hex_bad <= n_hex_bad;
        end
    end

endmodule
`default_nettype wire

// ===== design/jsu_serializer.sv =====
`default_nettype none
module jsu_serializer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  jsu_pkg::t_group     i_group,
    output logic                o_free,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_value,
    output logic [2:0]          o_error_code,
    output logic                o_last
);

    jsu_pkg::t_group r_grp;
    logic            r_valid;
    logic [1:0]      r_idx;
    jsu_pkg::t_result cur;
    logic            beat;
    logic            done;

    assign cur     = r_grp.res[r_idx];
    assign o_last  = (r_idx == 2'(r_grp.count - 3'd1));
    assign beat    = r_valid && !i_stall;
    assign done    = beat && o_last;
    assign o_free  = !r_valid || done;

    assign o_valid      = r_valid;
    assign o_kind       = cur.kind;
    assign o_value      = cur.value;
    assign o_error_code = cur.err;

    // control: group valid and beat index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (beat) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // group payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

endmodule
`default_nettype wire

// ===== design/json_string_unescape.sv =====
`default_nettype none
// Streaming JSON string body decoder. Bytes after the opening quote enter one
// per beat; each result beat carries a kind (decoded byte, string closed or
// error), the byte value, an error code and a last flag on the final result of
// that input byte. A byte with at most one result does not hold up the input,
// so plain text streams at one byte per clock while the receiver does not
// stall. A byte with n results (a \u escape yields up to three UTF-8 bytes plus
// a possible end-of-text error) holds the next byte while the output register
// hands out one result per cycle unless stalled. Bytes pass input then output register.
module json_string_unescape (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_text_ends,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_value,
    output logic [2:0]      o_error_code,
    output logic            o_last
);

    logic            r_in_valid;
    logic [7:0]      r_byte;
    logic            r_ends;
    jsu_pkg::t_group group;
    logic            ser_free;
    logic            advance;
    logic            load;

    // input byte moves on when its results fit, or it has none
    assign advance = r_in_valid && (group.count == 3'd0 || ser_free);
    assign load    = advance && (group.count != 3'd0);
    assign o_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_data_byte;
            r_ends <= i_text_ends;
        end
    end

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (r_byte),
        .i_text_ends (r_ends),
        .i_commit    (advance),
        .o_group     (group)
    );

    jsu_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_group      (group),
        .o_free       (ser_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
    import jsu_pkg::*;

    localparam int RANDOM_BYTES = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // one result beat as it should leave the decoder
    typedef struct packed {
        t_result    r;
        logic       last;
    } t_beat;

    // one input byte; fixed results are typed in where they are obvious
    typedef struct {
        logic [7:0] data;
        logic       ends;
        bit         fixed;
        int         cnt;
        t_result    r0;
        t_result    r1;
    } t_row;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_style;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_text_ends = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic [2:0] o_error_code;
    logic       o_last;

    json_string_unescape uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_text_ends  (i_text_ends),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    // decoder state mirrored by the predictor
    t_mode       dec_mode     = MODE_BODY;
    logic [15:0] code_acc     = 16'h0000;
    logic        hex_seen_bad = 1'b0;

    t_row  offered_bytes[$];
    t_beat decoded_q[$];
    t_beat fresh[$];
    t_row  dir_tab[$];
    t_row  took;
    t_beat want;

    int    errors     = 0;
    int    cyc        = 0;
    int    n_sent     = 0;
    int    burst_left = 0;
    int    idle_cyc   = 0;
    bit    hold_req   = 1'b0;
    string esc_chars  = "\"\\/bfnrt";

    task automatic report(input string msg);
        errors++;
        if (errors < 100)
            $display("MISMATCH cycle %0d: %s", cyc, msg);
    endtask

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic int esc_byte(input logic [7:0] c);
        case (c)
            "\"":    return 8'h22;
            "\\":    return 8'h5C;
            "/":     return 8'h2F;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            default: return -1;
        endcase
    endfunction

    function automatic void add_beat(ref t_beat q[$], input t_kind k, input logic [7:0] v,
                                     input logic [2:0] er);
        t_beat b;
        b.r.kind  = k;
        b.r.value = v;
        b.r.err   = er;
        b.last    = 1'b0;
        q.insert(q.size(), b);
    endfunction

    // expected beat appended to the scoreboard
    function automatic void queue_beat(input t_result r, input logic l);
        t_beat b;
        b.r    = r;
        b.last = l;
        decoded_q.insert(decoded_q.size(), b);
    endfunction

    function automatic void to_body();
        dec_mode     = MODE_BODY;
        code_acc     = 16'h0000;
        hex_seen_bad = 1'b0;
    endfunction

    // predictor: results caused by one byte, state updated in place
    function automatic void decode_byte(input logic [7:0] c, input logic ends,
                                        ref t_beat q[$]);
        int d;
        int h;
        case (dec_mode)
            MODE_ESC: begin
                d = esc_byte(c);
                if (c == "u") begin
                    if (ends) begin
                        add_beat(q, KIND_ERROR, 8'h00, ERR_INCOMPLETE_UNI);
                        to_body();
                    end else begin
                        dec_mode     = MODE_HEX1;
                        code_acc     = 16'h0000;
                        hex_seen_bad = 1'b0;
                    end
                end else if (d < 0) begin
                    add_beat(q, KIND_ERROR, 8'h00, ERR_BAD_ESCAPE);
                    to_body();
                end else begin
                    add_beat(q, KIND_BYTE, d[7:0], ERR_NONE);
                    dec_mode = MODE_BODY;
                    if (ends) begin
                        add_beat(q, KIND_ERROR, 8'h00, ERR_UNTERM_STRING);
                        to_body();
                    end
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                h = hex_digit(c);
                if (h < 0) hex_seen_bad = 1'b1;
                code_acc = {code_acc[11:0], (h < 0) ? 4'h0 : h[3:0]};
                if (dec_mode != MODE_HEX4) begin
                    if (ends) begin
                        add_beat(q, KIND_ERROR, 8'h00, ERR_INCOMPLETE_UNI);
                        to_body();
                    end else begin
                        dec_mode = t_mode'(dec_mode + 3'd1);
                    end
                end else if (hex_seen_bad) begin
                    add_beat(q, KIND_ERROR, 8'h00, ERR_BAD_HEX);
                    to_body();
                end else begin
                    // utf-8 encoding of the gathered code point
                    if (code_acc <= 16'h007F) begin
                        add_beat(q, KIND_BYTE, code_acc[7:0], ERR_NONE);
                    end else if (code_acc <= 16'h07FF) begin
                        add_beat(q, KIND_BYTE, 8'hC0 | {3'b000, code_acc[10:6]}, ERR_NONE);
                        add_beat(q, KIND_BYTE, 8'h80 | {2'b00, code_acc[5:0]}, ERR_NONE);
                    end else begin
                        add_beat(q, KIND_BYTE, 8'hE0 | {4'h0, code_acc[15:12]}, ERR_NONE);
                        add_beat(q, KIND_BYTE, 8'h80 | {2'b00, code_acc[11:6]}, ERR_NONE);
                        add_beat(q, KIND_BYTE, 8'h80 | {2'b00, code_acc[5:0]}, ERR_NONE);
                    end
                    if (ends) add_beat(q, KIND_ERROR, 8'h00, ERR_UNTERM_STRING);
                    to_body();
                end
            end
            default: begin
                if (c == "\"") begin
                    add_beat(q, KIND_CLOSE, 8'h00, ERR_NONE);
                    to_body();
                end else if (c == "\\") begin
                    if (ends) begin
                        add_beat(q, KIND_ERROR, 8'h00, ERR_UNTERM_ESCAPE);
                        to_body();
                    end else begin
                        dec_mode = MODE_ESC;
                    end
                end else begin
                    add_beat(q, KIND_BYTE, c, ERR_NONE);
                    dec_mode = MODE_BODY;
                    if (ends) begin
                        add_beat(q, KIND_ERROR, 8'h00, ERR_UNTERM_STRING);
                        to_body();
                    end
                end
            end
        endcase
        if (q.size() > 0) q[q.size()-1].last = 1'b1;
    endfunction

    function automatic t_result res(input t_kind k, input logic [7:0] v, input logic [2:0] er);
        t_result r;
        r.kind  = k;
        r.value = v;
        r.err   = er;
        return r;
    endfunction

    function automatic t_row plain_row(input logic [7:0] d, input logic e);
        t_row w;
        w.data  = d;
        w.ends  = e;
        w.fixed = 1'b0;
        w.cnt   = 0;
        w.r0    = res(KIND_BYTE, 8'h00, ERR_NONE);
        w.r1    = w.r0;
        return w;
    endfunction

    function automatic t_row known_row(input logic [7:0] d, input logic e, input int cnt,
                                       input t_result a, input t_result b);
        t_row w;
        w       = plain_row(d, e);
        w.fixed = 1'b1;
        w.cnt   = cnt;
        w.r0    = a;
        w.r1    = b;
        return w;
    endfunction

    // directed table row appended in order
    function automatic void add_row(input t_row w);
        dir_tab.insert(dir_tab.size(), w);
    endfunction

    // input and output beats, predicted and checked in edge order
    always @(posedge i_clk) begin
        cyc++;
        if (!i_rst_n) begin
            to_body();
        end else begin
            if (i_valid && !o_stall) begin
                took = offered_bytes.pop_front();
                fresh.delete();
                decode_byte(i_data_byte, i_text_ends, fresh);
                if (took.fixed) begin
                    if (took.cnt > 0) queue_beat(took.r0, took.cnt == 1);
                    if (took.cnt > 1) queue_beat(took.r1, 1'b1);
                end else begin
                    foreach (fresh[i]) decoded_q.insert(decoded_q.size(), fresh[i]);
                end
            end
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    report($sformatf("unexpected result kind %0d value %02h err %0d",
                                     o_kind, o_value, o_error_code));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_kind !== want.r.kind)
                        report($sformatf("kind %0d, expected %0d", o_kind, want.r.kind));
                    if (o_value !== want.r.value)
                        report($sformatf("value %02h, expected %02h", o_value, want.r.value));
                    if (o_error_code !== want.r.err)
                        report($sformatf("error code %0d, expected %0d",
                                         o_error_code, want.r.err));
                    if (o_last !== want.last)
                        report($sformatf("last %0d, expected %0d", o_last, want.last));
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    t_rx_style rx_style = RX_FREE;
    int        rx_left  = 0;
    int        hold_left = 0;
    int        rx_phase = 0;

    always @(posedge i_clk) begin
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 3));
                rx_left  = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_style)
                RX_FREE:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:  i_stall <= (rx_phase % 4 == 1);
            endcase
        end
    end

    // offer one byte, in bursts separated by random gaps
    task automatic send(input t_row w);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_valid     <= 1'b0;
                i_data_byte <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        offered_bytes.insert(offered_bytes.size(), w);
        i_data_byte <= w.data;
        i_text_ends <= w.ends;
        i_valid     <= 1'b1;
        n_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic put(input logic [7:0] d, input logic e);
        send(plain_row(d, e));
    endtask

    function automatic bit rare_end();
        return $urandom_range(0, 24) == 0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'("0") + 8'(nib);
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = "\"";
            1: c = "\\";
            default: begin
                do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
            end
        endcase
        return c;
    endfunction

    // one random fragment of string body, mostly well formed
    task automatic send_fragment();
        int          pick;
        int          bad_at;
        logic [15:0] cp;
        logic [7:0]  ch;
        logic        e;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            do ch = 8'($urandom_range(0, 255)); while (ch == "\"" || ch == "\\");
            put(ch, rare_end());
        end else if (pick < 55) begin
            e = rare_end();
            put("\\", e);
            if (!e) put(esc_chars[$urandom_range(0, 7)], rare_end());
        end else if (pick < 80) begin
            // unicode escape: code point class first, sometimes a bad digit
            e = rare_end();
            put("\\", 1'b0);
            put("u", e);
            if (!e) begin
                case ($urandom_range(0, 3))
                    0:       cp = 16'($urandom_range(0, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                endcase
                bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
                for (int i = 0; i < 4; i++) begin
                    ch = (i == bad_at) ? bad_hex_char() : hex_char(cp[15-4*i -: 4]);
                    e  = (i == 3) ? rare_end() : ($urandom_range(0, 39) == 0);
                    put(ch, e);
                    if (e) break;
                end
            end
        end else if (pick < 88) begin
            put("\"", 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
            put("\\", 1'b0);
            do ch = 8'($urandom_range(0, 255)); while (esc_byte(ch) >= 0 || ch == "u");
            put(ch, rare_end());
        end else begin
            put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    bit hold_done  = 1'b0;
    bit pause_done = 1'b0;
    int dir_count;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes: extremes, each escape path and each error
        add_row(known_row(8'h00, 1'b0, 1, res(KIND_BYTE, 8'h00, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row(8'hFF, 1'b0, 1, res(KIND_BYTE, 8'hFF, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("\"", 1'b1, 1, res(KIND_CLOSE, 8'h00, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("\\", 1'b0, 0, res(KIND_BYTE, 8'h00, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("n", 1'b0, 1, res(KIND_BYTE, 8'h0A, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("\\", 1'b0, 0, res(KIND_BYTE, 8'h00, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("x", 1'b0, 1, res(KIND_ERROR, 8'h00, ERR_BAD_ESCAPE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("\\", 1'b1, 1,
                          res(KIND_ERROR, 8'h00, ERR_UNTERM_ESCAPE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("z", 1'b1, 2, res(KIND_BYTE, "z", ERR_NONE),
                          res(KIND_ERROR, 8'h00, ERR_UNTERM_STRING)));
        add_row(known_row("\\", 1'b0, 0, res(KIND_BYTE, 8'h00, ERR_NONE),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        add_row(known_row("u", 1'b1, 1,
                          res(KIND_ERROR, 8'h00, ERR_INCOMPLETE_UNI),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        // largest code point, text ends on the last digit
        add_row(plain_row("\\", 1'b0));
        add_row(plain_row("u", 1'b0));
        add_row(plain_row("F", 1'b0));
        add_row(plain_row("f", 1'b0));
        add_row(plain_row("F", 1'b0));
        add_row(plain_row("f", 1'b1));
        // quote and backslash taken as non-hex digits
        add_row(plain_row("\\", 1'b0));
        add_row(plain_row("u", 1'b0));
        add_row(plain_row("0", 1'b0));
        add_row(plain_row("\"", 1'b0));
        add_row(plain_row("7", 1'b0));
        add_row(known_row("\\", 1'b1, 1, res(KIND_ERROR, 8'h00, ERR_BAD_HEX),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        // text ends on the second hex digit
        add_row(plain_row("\\", 1'b0));
        add_row(plain_row("u", 1'b0));
        add_row(plain_row("a", 1'b0));
        add_row(known_row("1", 1'b1, 1,
                          res(KIND_ERROR, 8'h00, ERR_INCOMPLETE_UNI),
                          res(KIND_BYTE, 8'h00, ERR_NONE)));
        dir_count = dir_tab.size();
        foreach (dir_tab[i]) send(dir_tab[i]);

        // random fragments, with one long receiver hold and one full drain
        while (n_sent < dir_count + RANDOM_BYTES) begin
            if (!hold_done && n_sent >= dir_count + 110) begin
                hold_done  = 1'b1;
                hold_req   = 1'b1;
                burst_left = 60;
            end
            if (!pause_done && n_sent >= dir_count + 220) begin
                pause_done = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (decoded_q.size() != 0);
                burst_left = 0;
            end
            send_fragment();
        end

        // drain, then allow for stray results
        i_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
